// ===== design/tus_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the code point encoder of the text-to-UTF-8 sanitizer.
// Has no dependencies; the engine, the top level and the checker use it by scoped names.
package tus_pkg;

  // Character set identifiers.
  localparam logic [15:0] CS_UTF8  = 16'h006A;
  localparam logic [15:0] CS_UCS2  = 16'h03E8;
  localparam logic [15:0] CS_U16BE = 16'h03F5;
  localparam logic [15:0] CS_U16LE = 16'h03F6;
  localparam logic [15:0] CS_U16   = 16'h03F7;

  localparam int MAX_TEXT_DEF  = 64;
  localparam int IN_Q_DEPTH    = 2;
  localparam int OUT_Q_DEPTH   = 4;
  localparam int PEND_MAX      = 6;

  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_absent;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // Encoded form of one code point: byte count and bytes, first byte at index 0.
  typedef struct packed {
    logic [2:0]      nb;
    logic [3:0][7:0] b;
  } enc_t;

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp <= 21'h7F) begin
      e.nb   = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.nb   = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.nb   = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.nb   = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ===== design/tus_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue used on the input side and between the engine and the result port.
// Depends on nothing but its parameters.
module tus_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  // Storage is written at the write pointer only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/tus_engine.sv =====
`timescale 1ns / 1ps
// Back end of the sanitizer: holds lookahead bytes, decodes UTF-8 or UTF-16 one step
// a cycle and emits result bytes one a cycle while the result queue has room. Depends on tus_pkg.
module tus_engine #(
  parameter int MAX_TEXT = tus_pkg::MAX_TEXT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         charset,
  input  logic                q_empty,
  input  tus_pkg::in_item_t   q_item,
  output logic                q_pop,
  input  logic                o_full,
  output logic                o_push,
  output tus_pkg::out_item_t  o_item
);

  localparam int EW = $clog2(MAX_TEXT + 1);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_EMIT, S_END} state_t;

  state_t          state_r;
  logic [3:0][7:0] held_r;
  logic [2:0]      hcnt_r;
  logic [EW-1:0]   ecnt_r;
  logic            le_r, start_r, halt_r, last_r;
  logic [2:0]      npend_r;
  logic            pv_r;
  logic [7:0]      pb_r;
  logic [3:0][7:0] eb_r;
  logic [2:0]      en_r, ei_r;

  // Step decision.
  logic            utf16, le, bom_step, loop_done;
  logic [2:0]      a_nb, a_drop;
  logic [3:0][7:0] a_b;
  logic            a_halt, a_brk;
  logic [15:0]     u0, u1;
  logic [7:0]      b0;
  logic            lead2, lead3, lead4, cont_ok;
  logic [2:0]      need;
  logic [20:0]     cp8, cp16;
  tus_pkg::enc_t   enc;
  logic [20:0]     enc_cp;
  logic [EW:0]     fit_sum;
  logic            fits;

  assign utf16 = (charset == tus_pkg::CS_UCS2) || (charset == tus_pkg::CS_U16BE) ||
                 (charset == tus_pkg::CS_U16LE) || (charset == tus_pkg::CS_U16);
  assign le    = (charset == tus_pkg::CS_U16) ? le_r : (charset == tus_pkg::CS_U16LE);
  assign bom_step = utf16 && (charset == tus_pkg::CS_U16) && start_r && (hcnt_r >= 3'd2);
  assign loop_done = halt_r || (utf16 ? (hcnt_r < 3'd2) : (hcnt_r == 3'd0));

  assign u0 = le ? {held_r[1], held_r[0]} : {held_r[0], held_r[1]};
  assign u1 = le ? {held_r[3], held_r[2]} : {held_r[2], held_r[3]};
  assign b0 = held_r[0];

  assign lead2 = (b0[7:5] == 3'b110);
  assign lead3 = (b0[7:4] == 4'b1110);
  assign lead4 = (b0[7:3] == 5'b11110);
  assign need  = lead2 ? 3'd2 : lead3 ? 3'd3 : 3'd4;
  assign cont_ok = (held_r[1][7:6] == 2'b10) &&
                   ((need < 3'd3) || (held_r[2][7:6] == 2'b10)) &&
                   ((need < 3'd4) || (held_r[3][7:6] == 2'b10));

  always_comb begin
    priority case (1'b1)
      lead2:   cp8 = {10'd0, b0[4:0], held_r[1][5:0]};
      lead3:   cp8 = {5'd0, b0[3:0], held_r[1][5:0], held_r[2][5:0]};
      default: cp8 = {b0[2:0], held_r[1][5:0], held_r[2][5:0], held_r[3][5:0]};
    endcase
  end

  // A surrogate pair always lands above the basic plane.
  assign cp16 = 21'h10000 + {1'b0, u0[9:0], u1[9:0]};

  always_comb begin
    if (utf16) begin
      enc_cp = ((u0 >= 16'hD800) && (u0 <= 16'hDBFF)) ? cp16 : {5'd0, u0};
    end else begin
      enc_cp = cp8;
    end
  end

  assign enc     = tus_pkg::encode_cp(enc_cp);
  assign fit_sum = {1'b0, ecnt_r} + (EW + 1)'(enc.nb);
  assign fits    = (fit_sum < (EW + 1)'(MAX_TEXT));

  // One decoding step: bytes to emit, bytes to drop, and whether to stop.
  always_comb begin
    logic [20:0] lo;
    a_nb   = 3'd0;
    a_b    = '0;
    a_drop = 3'd0;
    a_halt = 1'b0;
    a_brk  = 1'b0;
    lo     = lead2 ? 21'h80 : lead3 ? 21'h800 : 21'h10000;
    if (utf16) begin
      if ((u0 >= 16'hD800) && (u0 <= 16'hDBFF)) begin
        if (hcnt_r < 3'd4) begin
          if (!last_r) begin
            a_brk = 1'b1;
          end else begin
            a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK; a_drop = 3'd2;
          end
        end else if ((u1 >= 16'hDC00) && (u1 <= 16'hDFFF)) begin
          if (fits) begin
            a_nb = enc.nb; a_b = enc.b;
          end
          a_drop = 3'd4;
        end else begin
          a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK; a_drop = 3'd2;
        end
      end else if ((u0 >= 16'hDC00) && (u0 <= 16'hDFFF)) begin
        a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK; a_drop = 3'd2;
      end else begin
        if (fits) begin
          a_nb = enc.nb; a_b = enc.b;
        end
        a_drop = 3'd2;
      end
    end else begin
      if (b0 < 8'h80) begin
        a_nb = 3'd1; a_b[0] = (b0 >= tus_pkg::CH_SPACE) ? b0 : tus_pkg::CH_SPACE;
        a_drop = 3'd1;
      end else if (!(lead2 || lead3 || lead4)) begin
        a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK; a_drop = 3'd1;
      end else if (hcnt_r < need) begin
        a_brk = 1'b1;
        if (last_r) begin
          a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK; a_halt = 1'b1;
        end
      end else if (!cont_ok) begin
        a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK; a_drop = 3'd1;
      end else begin
        a_drop = need;
        if ((cp8 >= lo) && (cp8 <= 21'hFFFF) && ((cp8 < 21'hD800) || (cp8 > 21'hDFFF))) begin
          if (fits) begin
            a_nb = enc.nb; a_b = enc.b;
          end else begin
            a_halt = 1'b1;
          end
        end else begin
          a_nb = 3'd1; a_b[0] = tus_pkg::CH_QMARK;
        end
      end
    end
  end

  // Handshakes with the two queues.
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    o_push = 1'b0;
    o_item = '{out_byte: pb_r, out_valid: 1'b1, out_last: 1'b0};
    if (state_r == S_EMIT) begin
      o_push = pv_r && !o_full && (npend_r < 3'(tus_pkg::PEND_MAX));
    end else if (state_r == S_END) begin
      o_push = (pv_r || last_r) && !o_full;
      o_item = pv_r ? '{out_byte: pb_r, out_valid: 1'b1, out_last: last_r}
                    : '{out_byte: 8'd0, out_valid: 1'b0, out_last: 1'b1};
    end
  end

  // Sequencer and string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hcnt_r  <= 3'd0;
      ecnt_r  <= '0;
      le_r    <= 1'b0;
      start_r <= 1'b1;
      halt_r  <= 1'b0;
      last_r  <= 1'b0;
      npend_r <= 3'd0;
      pv_r    <= 1'b0;
      en_r    <= 3'd0;
      ei_r    <= 3'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            last_r  <= q_item.in_last;
            npend_r <= 3'd0;
            if (!halt_r && !q_item.byte_absent) begin
              if (hcnt_r < 3'd4) begin
                held_r[hcnt_r[1:0]] <= q_item.in_byte;
                hcnt_r <= hcnt_r + 3'd1;
              end
              if (charset != tus_pkg::CS_U16) begin
                start_r <= 1'b0;
              end
            end
            state_r <= halt_r ? S_END : S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (bom_step) begin
            // Byte order mark check on the first two bytes only.
            start_r <= 1'b0;
            le_r    <= (held_r[0] == 8'hFF) && (held_r[1] == 8'hFE);
            if (((held_r[0] == 8'hFF) && (held_r[1] == 8'hFE)) ||
                ((held_r[0] == 8'hFE) && (held_r[1] == 8'hFF))) begin
              held_r[0] <= held_r[2];
              held_r[1] <= held_r[3];
              hcnt_r    <= hcnt_r - 3'd2;
            end
          end else if (loop_done) begin
            state_r <= S_END;
          end else begin
            unique case (a_drop)
              3'd1: begin
                held_r[0] <= held_r[1];
                held_r[1] <= held_r[2];
                held_r[2] <= held_r[3];
              end
              3'd2: begin
                held_r[0] <= held_r[2];
                held_r[1] <= held_r[3];
              end
              3'd3: begin
                held_r[0] <= held_r[3];
              end
              default: ;
            endcase
            hcnt_r <= (a_drop >= hcnt_r) ? 3'd0 : hcnt_r - a_drop;
            if (a_halt) begin
              halt_r <= 1'b1;
            end
            eb_r <= a_b;
            en_r <= a_nb;
            ei_r <= 3'd0;
            if (a_nb != 3'd0) begin
              state_r <= S_EMIT;
            end else if (a_brk) begin
              state_r <= S_END;
            end
          end
        end
        S_EMIT: begin
          // The newest byte waits in a holding register so the last one can be flagged.
          if (!pv_r || !o_full || (npend_r >= 3'(tus_pkg::PEND_MAX))) begin
            if (npend_r < 3'(tus_pkg::PEND_MAX)) begin
              pv_r    <= 1'b1;
              pb_r    <= eb_r[ei_r[1:0]];
              npend_r <= npend_r + 3'd1;
            end
            ecnt_r <= ecnt_r + 1'b1;
            if (ecnt_r >= EW'(MAX_TEXT - 2)) begin
              halt_r <= 1'b1;
            end
            ei_r <= ei_r + 3'd1;
            if (ei_r == en_r - 3'd1) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_END: begin
          if (!(pv_r || last_r) || !o_full) begin
            pv_r    <= 1'b0;
            state_r <= S_IDLE;
            if (last_r) begin
              hcnt_r  <= 3'd0;
              ecnt_r  <= '0;
              le_r    <= 1'b0;
              start_r <= 1'b1;
              halt_r  <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/text_to_utf8_sanitizer_top.sv =====
`timescale 1ns / 1ps
// Top level of the text-to-UTF-8 sanitizer: input queue, decode engine, result queue.
// Depends on tus_pkg, tus_fifo and tus_engine.
//
// Usage: source bytes enter one per request on the in_ side (push/full, accepted when
// push is high and full is low). UTF-8 bytes leave on the out_ side as a queue: the
// oldest result sits on out_item while out_empty is low and is taken with out_pop.
// Every string ends with a result whose out_last is set; an item that yields nothing
// on the final request gives a bare marker with out_valid low.
// cfg_we/cfg_data write the character set ID; write it only while the block is idle.
// Sequence: the engine takes an item, then runs a decode step per character, dropped
// byte or BOM check and an emit step per result byte, then a step that finds nothing
// more can be decided and a closing step. A result shows on out_item in the cycle
// after the engine writes it. The sequencer handles one item at a time, so the next
// item starts only when the current one has closed.
// Reset clears both queues and the string state and sets the charset to UTF-8.
// When the receiver stalls, the result queue fills, the engine waits on its
// emit step and the input queue then raises in_full.
module text_to_utf8_sanitizer_top #(
  parameter int MAX_TEXT = tus_pkg::MAX_TEXT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  tus_pkg::in_item_t   in_item,
  output logic                in_full,
  output logic                out_empty,
  output tus_pkg::out_item_t  out_item,
  input  logic                out_pop,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);

  logic [15:0]        charset_r;
  logic               q_empty, q_pop, o_full, o_push;
  tus_pkg::in_item_t  q_item;
  tus_pkg::out_item_t o_item;

  // Character set register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_r <= tus_pkg::CS_UTF8;
    end else if (cfg_we) begin
      charset_r <= cfg_data;
    end
  end

  // Front: queue of accepted requests.
  tus_fifo #(
    .WIDTH ($bits(tus_pkg::in_item_t)),
    .DEPTH (tus_pkg::IN_Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (in_item),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  // Back: decode and emit.
  tus_engine #(
    .MAX_TEXT (MAX_TEXT)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .charset (charset_r),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_item  (o_item)
  );

  // Result queue.
  tus_fifo #(
    .WIDTH ($bits(tus_pkg::out_item_t)),
    .DEPTH (tus_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_item),
    .full  (o_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule

// ===== design/tus_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sanitizer and the bind that attaches them to the top level.
// Depends on tus_pkg and text_to_utf8_sanitizer_top.
module tus_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input tus_pkg::out_item_t out_item
);

  // The result queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A result without a byte is only the end marker of a string.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.out_valid) |-> (out_item.out_last && out_item.out_byte == 8'd0))
    else $error("bare result is not a clean end marker");

  // Output bytes are never overlong or out-of-range UTF-8 lead bytes.
  a_utf8_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.out_valid) |->
      (out_item.out_byte != 8'hC0 && out_item.out_byte != 8'hC1 &&
       out_item.out_byte < 8'hF5))
    else $error("invalid UTF-8 byte on output");

  // A waiting result is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed before pop");

endmodule

bind text_to_utf8_sanitizer_top tus_checker u_tus_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);
